>>> sv/wavetable_sound_chip_regs_top_defines.svh
// Assertion helpers for the sound chip RTL
`ifndef WAVETABLE_SOUND_CHIP_REGS_TOP_DEFINES_SVH
`define WAVETABLE_SOUND_CHIP_REGS_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define WTSC_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("wtsc: same-cycle check failed");

// next-cycle implication, checked out of reset
`define WTSC_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("wtsc: next-cycle check failed");

`endif

>>> sv/wtsc_pkg.sv
`timescale 1ns / 1ps
package wtsc_pkg;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] REQ_RSVD  = 2'd3;

    localparam logic [7:0]  ENABLE_CODE = 8'h3F;
    localparam logic [7:0]  OPEN_BUS    = 8'hFF;
    localparam int          NCHAN       = 5;
    // ceil(2^19 / 75): (m * MIX_RECIP) >> 19 is floor(m / 75) for every m up to 9600
    localparam logic [12:0] MIX_RECIP   = 13'd6991;
    localparam logic [8:0]  MIX_BIAS    = 9'd128;
    localparam logic [8:0]  SAMPLE_MAX  = 9'd255;

    typedef struct packed {
        logic       is_win;
        logic       is_wave;
        logic       is_freq_lo;
        logic       is_freq_hi;
        logic       is_vol;
        logic       is_mask;
        logic [2:0] chan;
        logic [6:0] wave_addr;
    } dec_t;

endpackage

>>> sv/wtsc_dec.sv
`timescale 1ns / 1ps
module wtsc_dec
    import wtsc_pkg::*;
(
    input  logic [12:0] offset,
    output dec_t        dec
);

    logic [10:0] r;
    logic        grp8;
    logic [3:0]  lo;
    logic [3:0]  vol_ch;

    assign r      = offset[10:0];
    assign lo     = r[3:0];
    assign grp8   = (r[10:4] == 7'h08);
    assign vol_ch = lo - 4'd10;

    always_comb
    begin
        dec            = '0;
        dec.is_win     = (offset[12:11] == 2'b11);
        dec.is_wave    = (r[10:7] == 4'd0);
        dec.is_freq_lo = grp8 && (lo <= 4'd9) && !lo[0];
        dec.is_freq_hi = grp8 && (lo <= 4'd9) && lo[0];
        dec.is_vol     = grp8 && (lo >= 4'd10) && (lo <= 4'd14);
        dec.is_mask    = grp8 && (lo == 4'd15);
        dec.chan       = dec.is_vol ? vol_ch[2:0] : lo[3:1];
        dec.wave_addr  = r[6:0];
    end

endmodule

>>> sv/wtsc_div.sv
`timescale 1ns / 1ps
module wtsc_div
    import wtsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] num,
    input  logic [12:0] den,
    output logic        busy,
    output logic        done,
    output logic [15:0] quot,
    output logic [12:0] rem
);

    logic [15:0] num_reg;
    logic [12:0] rem_reg;
    logic [12:0] den_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [13:0] part;
    logic        ge;
    logic [13:0] diff;
    logic [12:0] rem_next;

    assign part     = {rem_reg, num_reg[15]};
    assign ge       = part >= {1'b0, den_reg};
    assign diff     = part - {1'b0, den_reg};
    assign rem_next = ge ? diff[12:0] : part[12:0];

    // one quotient bit per cycle, quotient shifts in behind the dividend
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[14:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = num_reg;
    assign rem  = rem_reg;

endmodule

>>> sv/wavetable_sound_chip_regs_top.sv
`timescale 1ns / 1ps
// Five-channel wavetable sound chip register block. Each beat carries a bus
// write, a bus read, a sample tick or a reserved request that does nothing, and
// yields one result beat. A tick walks the channels one at a time: each enabled
// channel goes through the 16-step bit-serial divider that wraps the phase, and
// each disabled one is skipped; the final scaling by 75 is a reciprocal multiply
// in S_MIX followed by bias and clamp in S_MIXDIV. A stalled result beat holds
// the block for as long as out_stall stays high. Waveforms sit in a 128x8 RAM
// and per-channel phase in a 5-entry RAM, both with registered reads.
module wavetable_sound_chip_regs_top
    import wtsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [12:0] offset,
    input  logic [7:0]  wdata,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        read_hit,
    output logic [7:0]  read_data,
    output logic [7:0]  sample_out,
    output logic [7:0]  rom_bank,
    output logic        window_enabled
);

`include "wavetable_sound_chip_regs_top_defines.svh"

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD     = 4'd1;
    localparam logic [3:0] S_T_RD   = 4'd2;
    localparam logic [3:0] S_T_ADD  = 4'd3;
    localparam logic [3:0] S_T_DIV  = 4'd4;
    localparam logic [3:0] S_T_MAC  = 4'd5;
    localparam logic [3:0] S_MIX    = 4'd6;
    localparam logic [3:0] S_MIXDIV = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]  state_reg;
    logic [23:0] step_reg;
    logic        window_on_reg;
    logic [7:0]  bank_sel_reg;
    logic [11:0] freq_reg [NCHAN];
    logic [3:0]  vol_reg [NCHAN];
    logic [4:0]  mask_reg;

    logic [7:0]  wave_mem [128];
    logic [127:0] wave_vld_reg;
    logic [7:0]  wave_rdata_reg;
    logic        wave_rvld_reg;
    logic        wave_we;
    logic        wave_re;
    logic [6:0]  wave_raddr;

    logic [36:0] chan_mem [NCHAN];
    logic [NCHAN-1:0] chan_vld_reg;
    logic [36:0] chan_rdata_reg;
    logic        chan_rvld_reg;
    logic        chan_re;
    logic        chan_we;
    logic [36:0] chan_wdata;

    logic [2:0]  ch_reg;
    logic [31:0] sum_reg;
    logic [4:0]  idx_reg;
    logic signed [14:0] mix_reg;
    logic        neg_reg;
    logic [7:0]  quot_reg;
    logic        res_hit_reg;
    logic [7:0]  res_rd_reg;
    logic [7:0]  res_smp_reg;

    logic        out_valid_reg;
    logic        out_hit_reg;
    logic [7:0]  out_rd_reg;
    logic [7:0]  out_smp_reg;
    logic [7:0]  out_bank_reg;
    logic        out_win_reg;

    dec_t        dec;
    logic        in_acc;
    logic        div_start;
    logic        div_busy;
    logic        div_done;
    logic [15:0] div_num;
    logic [12:0] div_den;
    logic [15:0] div_quot;
    logic [12:0] div_rem;

    logic [31:0] phase_cur;
    logic [4:0]  idx_cur;
    logic [31:0] sum_next;
    logic [4:0]  idx_next;
    logic [1:0]  wave_ch;
    logic [7:0]  wave_byte;
    logic signed [12:0] prod;
    logic [13:0] mix_mag;
    logic [26:0] mix_prod;
    logic [8:0]  smp_wide;
    logic        out_load;

    wtsc_dec u_dec (
        .offset (offset),
        .dec    (dec)
    );

    wtsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;

    assign phase_cur = chan_rvld_reg ? chan_rdata_reg[31:0] : 32'd0;
    assign idx_cur   = chan_rvld_reg ? chan_rdata_reg[36:32] : 5'd0;
    assign sum_next  = phase_cur + {8'd0, step_reg};
    assign idx_next  = idx_reg + div_quot[4:0];
    assign wave_ch   = (ch_reg == 3'd4) ? 2'd3 : ch_reg[1:0];
    assign wave_byte = wave_rvld_reg ? wave_rdata_reg : 8'd0;
    assign prod      = $signed(wave_byte) * $signed({1'b0, vol_reg[ch_reg]});
    assign mix_mag   = mix_reg[14] ? 14'(-mix_reg) : mix_reg[13:0];
    assign mix_prod  = {13'd0, mix_mag} * {14'd0, MIX_RECIP};

    // divider wraps the phase: (sum >> 16) over (freq + 1)
    assign div_start = (state_reg == S_T_ADD);
    assign div_num   = sum_next[31:16];
    assign div_den   = {1'b0, freq_reg[ch_reg]} + 13'd1;

    assign smp_wide  = neg_reg ? (MIX_BIAS - {1'b0, quot_reg})
                               : (MIX_BIAS + {1'b0, quot_reg});

    assign wave_we    = in_acc && (req_type == REQ_WRITE) && dec.is_win && window_on_reg
                        && dec.is_wave;
    assign wave_re    = (in_acc && (req_type == REQ_READ))
                        || ((state_reg == S_T_DIV) && div_done);
    assign wave_raddr = (state_reg == S_IDLE) ? dec.wave_addr : {wave_ch, idx_next};

    assign chan_re    = (state_reg == S_T_RD) && mask_reg[ch_reg];
    assign chan_we    = (state_reg == S_T_DIV) && div_done;
    assign chan_wdata = {idx_next, 3'd0, div_rem, sum_reg[15:0]};

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // waveform RAM
    always_ff @(posedge clk)
    begin
        if (wave_we)
            wave_mem[dec.wave_addr] <= wdata;
        if (wave_re)
            wave_rdata_reg <= wave_mem[wave_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_vld_reg  <= '0;
            wave_rvld_reg <= 1'b0;
        end
        else
        begin
            if (wave_we)
                wave_vld_reg[dec.wave_addr] <= 1'b1;
            if (wave_re)
                wave_rvld_reg <= wave_vld_reg[wave_raddr];
        end
    end

    // channel phase RAM: {wave index, pad, phase}
    always_ff @(posedge clk)
    begin
        if (chan_we)
            chan_mem[ch_reg] <= chan_wdata;
        if (chan_re)
            chan_rdata_reg <= chan_mem[ch_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_vld_reg  <= '0;
            chan_rvld_reg <= 1'b0;
        end
        else
        begin
            if (chan_we)
                chan_vld_reg[ch_reg] <= 1'b1;
            if (chan_re)
                chan_rvld_reg <= chan_vld_reg[ch_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= 24'd5319480;
        else if (cfg_we)
            step_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_on_reg <= 1'b0;
            bank_sel_reg  <= '0;
            mask_reg      <= '0;
            for (int i = 0; i < NCHAN; i++)
            begin
                freq_reg[i] <= '0;
                vol_reg[i]  <= '0;
            end
            ch_reg      <= '0;
            sum_reg     <= '0;
            idx_reg     <= '0;
            mix_reg     <= '0;
            neg_reg     <= 1'b0;
            quot_reg    <= '0;
            res_hit_reg <= 1'b0;
            res_rd_reg  <= '0;
            res_smp_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        res_hit_reg <= 1'b0;
                        res_rd_reg  <= '0;
                        res_smp_reg <= '0;
                        state_reg   <= S_DONE;
                        case (req_type)
                            REQ_WRITE:
                            begin
                                if (!dec.is_win)
                                begin
                                    if (wdata == ENABLE_CODE)
                                        window_on_reg <= 1'b1;
                                    else
                                    begin
                                        window_on_reg <= 1'b0;
                                        bank_sel_reg  <= wdata;
                                    end
                                end
                                else if (window_on_reg)
                                begin
                                    if (dec.is_freq_lo)
                                        freq_reg[dec.chan][7:0] <= wdata;
                                    if (dec.is_freq_hi)
                                        freq_reg[dec.chan][11:8] <= wdata[3:0];
                                    if (dec.is_vol)
                                        vol_reg[dec.chan] <= wdata[3:0];
                                    if (dec.is_mask)
                                        mask_reg <= wdata[4:0];
                                end
                            end
                            REQ_READ:
                            begin
                                if (window_on_reg && dec.is_win)
                                begin
                                    res_hit_reg <= 1'b1;
                                    if (dec.is_wave)
                                        state_reg <= S_RD;
                                    else
                                        res_rd_reg <= OPEN_BUS;
                                end
                            end
                            REQ_TICK:
                            begin
                                ch_reg    <= '0;
                                mix_reg   <= '0;
                                state_reg <= S_T_RD;
                            end
                            default:
                            begin
                                res_hit_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    res_rd_reg <= wave_byte;
                    state_reg  <= S_DONE;
                end
                S_T_RD:
                begin
                    if (mask_reg[ch_reg])
                        state_reg <= S_T_ADD;
                    else if (ch_reg == 3'd4)
                        state_reg <= S_MIX;
                    else
                        ch_reg <= ch_reg + 3'd1;
                end
                S_T_ADD:
                begin
                    sum_reg   <= sum_next;
                    idx_reg   <= idx_cur;
                    state_reg <= S_T_DIV;
                end
                S_T_DIV:
                begin
                    if (div_done)
                        state_reg <= S_T_MAC;
                end
                S_T_MAC:
                begin
                    mix_reg <= mix_reg + 15'(prod);
                    if (ch_reg == 3'd4)
                        state_reg <= S_MIX;
                    else
                    begin
                        ch_reg    <= ch_reg + 3'd1;
                        state_reg <= S_T_RD;
                    end
                end
                S_MIX:
                begin
                    // scale the magnitude by 1/75, sign goes back on next cycle
                    neg_reg   <= mix_reg[14];
                    quot_reg  <= mix_prod[26:19];
                    state_reg <= S_MIXDIV;
                end
                S_MIXDIV:
                begin
                    res_smp_reg <= (smp_wide > SAMPLE_MAX) ? 8'hFF : smp_wide[7:0];
                    state_reg   <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // output register: hold the beat while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hit_reg  <= res_hit_reg;
            out_rd_reg   <= res_rd_reg;
            out_smp_reg  <= res_smp_reg;
            out_bank_reg <= bank_sel_reg;
            out_win_reg  <= window_on_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_hit       = out_hit_reg;
    assign read_data      = out_rd_reg;
    assign sample_out     = out_smp_reg;
    assign rom_bank       = out_bank_reg;
    assign window_enabled = out_win_reg;

    `WTSC_ASSERT_IMP(a_miss_zero, out_valid && !read_hit, read_data == 8'd0)
    `WTSC_ASSERT_IMP(a_div_idle_start, div_start, !div_busy)
    `WTSC_ASSERT_NXT(a_accept_busy, in_acc, state_reg != S_IDLE)
    `WTSC_ASSERT_IMP(a_mix_range, 1'b1, (mix_reg >= -15'sd9600) && (mix_reg <= 15'sd9600))

endmodule
